// File: src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled while reset is asserted
`define VGBD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked check on the cycle after the condition
`define VGBD_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: src/vgbd_pkg.sv
package vgbd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIV_STEPS  = 8;
    localparam int REM_W      = 18;
    localparam int NUM_CH     = 3;

    localparam logic [1:0] REG_TOP_COLOR    = 2'd0;
    localparam logic [1:0] REG_BOTTOM_COLOR = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    typedef struct packed {
        logic [7:0]       t8;
        logic             neg;
        logic [REM_W-1:0] rem;
        logic [7:0]       quo;
    } chan_t;

    typedef struct packed {
        logic              valid;
        logic              in_frame;
        logic              one_row;
        logic [3:0]        dith;
        logic [19:0]       addr;
        chan_t [NUM_CH-1:0] ch;
    } pix_t;

    function automatic logic [10:0] clamp_dim(input logic [10:0] v, input logic [10:0] maxv);
        logic [10:0] r;
        begin
            r = v;
            if (v == 11'd0) begin
                r = 11'd1;
            end else if (v > maxv) begin
                r = maxv;
            end
            return r;
        end
    endfunction

    function automatic logic [3:0] bayer(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] d;
        begin
            case ({row, col})
                4'h0: d = 4'd0;
                4'h1: d = 4'd8;
                4'h2: d = 4'd2;
                4'h3: d = 4'd10;
                4'h4: d = 4'd12;
                4'h5: d = 4'd4;
                4'h6: d = 4'd14;
                4'h7: d = 4'd6;
                4'h8: d = 4'd3;
                4'h9: d = 4'd11;
                4'hA: d = 4'd1;
                4'hB: d = 4'd9;
                4'hC: d = 4'd15;
                4'hD: d = 4'd7;
                4'hE: d = 4'd13;
                4'hF: d = 4'd5;
                default: d = 4'd0;
            endcase
            return d;
        end
    endfunction

endpackage

// File: src/vgbd_front.sv
module vgbd_front
    import vgbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [9:0]  pixel_x,
    input  logic [9:0]  pixel_y,
    input  logic [15:0] top_color,
    input  logic [15:0] bottom_color,
    input  logic [10:0] width_c,
    input  logic [10:0] height_c,
    output pix_t        out_reg
);

    pix_t        stage_next;
    logic [7:0]  t8 [NUM_CH];
    logic [7:0]  b8 [NUM_CH];
    logic [7:0]  mag;
    logic [20:0] row_base;

    always_comb begin
        t8[CH_RED]   = {top_color[15:11], 3'b000};
        t8[CH_GREEN] = {top_color[10:5], 2'b00};
        t8[CH_BLUE]  = {top_color[4:0], 3'b000};
        b8[CH_RED]   = {bottom_color[15:11], 3'b000};
        b8[CH_GREEN] = {bottom_color[10:5], 2'b00};
        b8[CH_BLUE]  = {bottom_color[4:0], 3'b000};
    end

    always_comb begin
        stage_next          = '0;
        mag                 = '0;
        row_base            = 21'(pixel_y) * 21'(width_c);
        stage_next.valid    = in_valid;
        stage_next.in_frame = ({1'b0, pixel_x} < width_c) && ({1'b0, pixel_y} < height_c);
        stage_next.one_row  = (height_c == 11'd1);
        stage_next.dith     = bayer(pixel_y[1:0], pixel_x[1:0]);
        stage_next.addr     = row_base[19:0] + 20'(pixel_x);
        for (int c = 0; c < NUM_CH; c++) begin
            stage_next.ch[c].t8  = t8[c];
            stage_next.ch[c].neg = (b8[c] < t8[c]);
            mag = stage_next.ch[c].neg ? (t8[c] - b8[c]) : (b8[c] - t8[c]);
            stage_next.ch[c].rem = REM_W'(mag) * REM_W'(pixel_y);
            stage_next.ch[c].quo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else if (en) begin
            out_reg <= stage_next;
        end
    end

endmodule

// File: src/vgbd_divider.sv
module vgbd_divider
    import vgbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [9:0] divisor,
    input  pix_t       in_pix,
    output pix_t       out_pix
);

    pix_t stage_reg [DIV_STEPS+1];

    assign stage_reg[0] = in_pix;
    assign out_pix      = stage_reg[DIV_STEPS];

    // restoring division, one quotient bit per stage, msb first
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        localparam int K = DIV_STEPS - 1 - i;
        pix_t             step_next;
        logic [REM_W-1:0] dsh;

        always_comb begin
            dsh       = REM_W'(divisor) << K;
            step_next = stage_reg[i];
            for (int c = 0; c < NUM_CH; c++) begin
                if (stage_reg[i].ch[c].rem >= dsh) begin
                    step_next.ch[c].rem    = stage_reg[i].ch[c].rem - dsh;
                    step_next.ch[c].quo[K] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_reg[i+1] <= '0;
            end else if (en) begin
                stage_reg[i+1] <= step_next;
            end
        end
    end

endmodule

// File: src/vgbd_back.sv
module vgbd_back
    import vgbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  pix_t        in_pix,
    output logic        valid_reg,
    output logic [15:0] color_reg,
    output logic [19:0] addr_reg,
    output logic        inside_reg
);

    logic [9:0]  v;
    logic [9:0]  sum;
    logic [2:0]  off;
    logic [6:0]  lvl;
    logic [4:0]  r5, b5;
    logic [5:0]  g6;
    logic [15:0] color_next;

    always_comb begin
        r5 = '0;
        g6 = '0;
        b5 = '0;
        v  = '0;
        sum = '0;
        off = '0;
        lvl = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            if (in_pix.one_row) begin
                v = {2'b00, in_pix.ch[c].t8};
            end else if (in_pix.ch[c].neg) begin
                v = {2'b00, in_pix.ch[c].t8} - {2'b00, in_pix.ch[c].quo};
            end else begin
                v = {2'b00, in_pix.ch[c].t8} + {2'b00, in_pix.ch[c].quo};
            end
            if (v[9]) begin
                v = '0;
            end
            off = (c == CH_GREEN) ? {1'b0, in_pix.dith[3:2]} : in_pix.dith[3:1];
            sum = v + 10'(off);
            if (c == CH_GREEN) begin
                lvl = 7'(sum >> 2);
                g6  = (lvl > 7'd63) ? 6'd63 : lvl[5:0];
            end else begin
                lvl = 7'(sum >> 3);
                if (c == CH_RED) begin
                    r5 = (lvl > 7'd31) ? 5'd31 : lvl[4:0];
                end else begin
                    b5 = (lvl > 7'd31) ? 5'd31 : lvl[4:0];
                end
            end
        end
        color_next = {r5, g6, b5};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_pix.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inside_reg <= in_pix.in_frame;
            color_reg  <= in_pix.in_frame ? color_next : 16'd0;
            addr_reg   <= in_pix.in_frame ? in_pix.addr : 20'd0;
        end
    end

endmodule

// File: src/vertical_gradient_bayer_dither.sv
// channel   dir  tdata / data                          tuser
// s_        in   [9:0] pixel_x, [19:10] pixel_y         -
// m_        out  [15:0] pixel_color, [35:16] address    [0] in_frame
// cfg_      in   write enable, 2-bit index, 16-bit data
//
// one transaction per cycle while m_ does not stall; the pipeline is
// front stage, 8 divide stages, output stage
// the divide stages take one quotient bit each, which sets the depth
// aresetn is synchronous; it clears the valid bits and the front and divide stages
// a stall on m_ freezes every stage at once, s_tready follows it

`include "assert_macros.svh"

module vertical_gradient_bayer_dither
    import vgbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] pixel_x, [19:10] pixel_y, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] pixel_color, [35:16] pixel_address, rest zero
    output logic        m_tuser,   // [0] in_frame
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [15:0] top_color_reg;
    logic [15:0] bottom_color_reg;
    logic [10:0] frame_width_reg;
    logic [10:0] frame_height_reg;

    logic [10:0] width_c;
    logic [10:0] height_c;
    logic [9:0]  divisor;
    logic        adv;

    pix_t front_pix;
    pix_t div_pix;

    logic [15:0] color_out;
    logic [19:0] addr_out;
    logic        inside_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_color_reg    <= 16'd0;
            bottom_color_reg <= 16'd0;
            frame_width_reg  <= 11'd320;
            frame_height_reg <= 11'd240;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TOP_COLOR:    top_color_reg    <= cfg_data;
                REG_BOTTOM_COLOR: bottom_color_reg <= cfg_data;
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the maximum acts as the maximum
    assign width_c  = clamp_dim(frame_width_reg, 11'(MAX_WIDTH));
    assign height_c = clamp_dim(frame_height_reg, 11'(MAX_HEIGHT));
    // height minus one is the interpolation divisor; single row bypasses it
    assign divisor  = 10'(height_c - 11'd1);

    // whole pipeline moves when the output register is free or drained
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    vgbd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .in_valid     (s_tvalid),
        .pixel_x      (s_tdata[9:0]),
        .pixel_y      (s_tdata[19:10]),
        .top_color    (top_color_reg),
        .bottom_color (bottom_color_reg),
        .width_c      (width_c),
        .height_c     (height_c),
        .out_reg      (front_pix)
    );

    vgbd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .divisor (divisor),
        .in_pix  (front_pix),
        .out_pix (div_pix)
    );

    vgbd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_pix     (div_pix),
        .valid_reg  (m_tvalid),
        .color_reg  (color_out),
        .addr_reg   (addr_out),
        .inside_reg (inside_out)
    );

    assign m_tdata = {4'd0, addr_out, color_out};
    assign m_tuser = inside_out;

    // out-of-frame transactions carry an all-zero payload
    `VGBD_ASSERT(a_outside_zero, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata == 40'd0), "outside pixel not zeroed")

    // a single-row frame reproduces the top color exactly
    `VGBD_ASSERT(a_one_row, aclk, aresetn, (m_tvalid && m_tuser && (height_c == 11'd1)) |-> (m_tdata[15:0] == top_color_reg), "single row color mismatch")

endmodule
